FILE: hw/rtl/s128_pkg.sv
// Package: types, opcodes and status codes of the signed 128-bit checked ALU.
package s128_pkg;
   localparam int WordWidth = 64;
   localparam int FullWidth = 2 * WordWidth;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_REM = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OVF  = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;

   typedef struct packed {
      logic [2:0]               opcode;
      logic signed [WordWidth-1:0] a_high;
      logic [WordWidth-1:0]        a_low;
      logic signed [WordWidth-1:0] b_high;
      logic [WordWidth-1:0]        b_low;
   } req_type;

   typedef struct packed {
      logic signed [WordWidth-1:0] result_high;
      logic [WordWidth-1:0]        result_low;
      logic [1:0]                  status;
   } rsp_type;
endpackage

FILE: hw/rtl/s128_serial_core.sv
// Bit-serial core: add/sub, shift-add multiply and restoring divide on magnitudes.
module s128_serial_core import s128_pkg::*; #(
   parameter int Width = FullWidth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [2:0]       op,
   input  logic [Width-1:0] x,
   input  logic [Width-1:0] y,
   output logic             done,
   output logic [Width-1:0] res,
   output logic             ovf
);
   localparam int CntWidth = $clog2(Width + 1);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;

   logic [1:0]          state_ff, state_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic [Width-1:0]    acc_ff, acc_in;   // sum / product / remainder
   logic [Width-1:0]    sh_ff, sh_in;     // addend / multiplier / dividend-quotient
   logic [Width-1:0]    opd_ff, opd_in;   // multiplicand or divisor
   logic [2:0]          op_ff, op_in;
   logic                carry_ff, carry_in;
   logic                ovf_ff, ovf_in;
   logic                done_ff, done_in;

   logic [Width:0]      trial;
   logic [Width:0]      madd;
   logic                sum_bit;

   always_comb begin
      trial   = {acc_ff, sh_ff[Width-1]} - {1'b0, opd_ff};
      madd    = {1'b0, acc_ff} + {1'b0, opd_ff};
      sum_bit = acc_ff[0] ^ sh_ff[0] ^ carry_ff;
      state_in = state_ff; count_in = count_ff; acc_in = acc_ff; sh_in = sh_ff;
      opd_in = opd_ff; op_in = op_ff; carry_in = carry_ff; ovf_in = ovf_ff;
      done_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (go) begin
               state_in = S_RUN;
               count_in = '0;
               op_in    = op;
               ovf_in   = 1'b0;
               case (op)
                  OP_ADD: begin acc_in = x; sh_in = y;  carry_in = 1'b0; end
                  OP_SUB: begin acc_in = x; sh_in = ~y; carry_in = 1'b1; end
                  OP_MUL: begin acc_in = '0; sh_in = y; opd_in = x; end
                  default: begin acc_in = '0; sh_in = x; opd_in = y; end
               endcase
            end
         end
         S_RUN: begin
            case (op_ff)
               OP_ADD, OP_SUB: begin
                  // LSB-first ripple, result shifts into acc from the top
                  acc_in   = {sum_bit, acc_ff[Width-1:1]};
                  carry_in = (acc_ff[0] & sh_ff[0]) | (carry_ff & (acc_ff[0] ^ sh_ff[0]));
                  sh_in    = {1'b0, sh_ff[Width-1:1]};
               end
               OP_MUL: begin
                  // product grows MSB first; any carry past the top overflows
                  if (acc_ff[Width-1]) ovf_in = 1'b1;
                  if (sh_ff[Width-1]) begin
                     madd = {acc_ff, 1'b0} + {1'b0, opd_ff};
                     if (madd[Width]) ovf_in = 1'b1;
                     acc_in = madd[Width-1:0];
                  end else begin
                     acc_in = {acc_ff[Width-2:0], 1'b0};
                  end
                  sh_in = {sh_ff[Width-2:0], 1'b0};
               end
               default: begin
                  if (!trial[Width]) begin
                     acc_in = trial[Width-1:0];
                     sh_in  = {sh_ff[Width-2:0], 1'b1};
                  end else begin
                     acc_in = {acc_ff[Width-2:0], sh_ff[Width-1]};
                     sh_in  = {sh_ff[Width-2:0], 1'b0};
                  end
               end
            endcase
            count_in = count_ff + 1'b1;
            if (count_ff == CntWidth'(Width - 1)) begin
               state_in = S_IDLE;
               done_in  = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      count_ff <= count_in; acc_ff <= acc_in; sh_ff <= sh_in; opd_ff <= opd_in;
      op_ff <= op_in; carry_ff <= carry_in; ovf_ff <= ovf_in;
   end

   assign done = done_ff;
   assign ovf  = ovf_ff;
   assign res  = (op_ff == OP_DIV) ? sh_ff : acc_ff;
endmodule

FILE: hw/rtl/signed_int128_checked_alu.sv
// Top level: signed 128-bit checked ALU, sign handling around a bit-serial core.
// For add, sub, mul, div and rem the core walks all 128 bits, one per cycle, and the
// sign fix-up is then registered into the result before rsp_valid.
// Errors found at entry (minimum operand, bad opcode, zero divisor) skip the core and go through the error state.
// A new transaction is taken only while idle; busy is high while one is in progress.
// Synchronous active-high reset returns to idle; the receiver cannot stall.
module signed_int128_checked_alu import s128_pkg::*; #(
   parameter int Width = FullWidth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_ERR  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [2:0]       op_ff;
   logic             na_ff, nb_ff;
   logic [1:0]       err_ff;
   logic             valid_ff;
   rsp_type          rsp_ff;

   logic [Width-1:0] a, b, ma, mb, cx, cy, cres, fixed;
   logic             cdone, covf, go, sneg;
   logic [1:0]       err;
   logic [Width-1:0] minv;

   always_comb begin
      minv = {1'b1, {(Width-1){1'b0}}};
      a  = {req_data.a_high, req_data.a_low};
      b  = {req_data.b_high, req_data.b_low};
      ma = a[Width-1] ? -a : a;
      mb = b[Width-1] ? -b : b;
      cx = (req_data.opcode == OP_ADD || req_data.opcode == OP_SUB) ? a : ma;
      cy = (req_data.opcode == OP_ADD || req_data.opcode == OP_SUB) ? b : mb;
      err = ST_OK;
      if (a == minv || b == minv || req_data.opcode > OP_REM) err = ST_OVF;
      else if ((req_data.opcode == OP_DIV || req_data.opcode == OP_REM) && b == '0)
         err = ST_DIV0;
      go = start && !busy && err == ST_OK;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (start) state_in = (err == ST_OK) ? S_RUN : S_ERR;
         S_RUN:  if (cdone) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      // sign fix-up on the core result; the overflow checks are in the block below
      case (op_ff)
         OP_MUL:  sneg = na_ff ^ nb_ff;
         OP_DIV:  sneg = na_ff ^ nb_ff;
         OP_REM:  sneg = na_ff;
         default: sneg = 1'b0;
      endcase
      fixed = sneg ? -cres : cres;
   end

   s128_serial_core #(.Width(Width)) u_core (
      .clock(clock), .reset(reset), .go(go), .op(req_data.opcode),
      .x(cx), .y(cy), .done(cdone), .res(cres), .ovf(covf)
   );

   logic bad;
   always_comb begin
      case (op_ff)
         OP_ADD:  bad = (na_ff == nb_ff && cres[Width-1] != na_ff) || cres == minv;
         OP_SUB:  bad = (na_ff != nb_ff && cres[Width-1] != na_ff) || cres == minv;
         OP_MUL:  bad = covf || cres[Width-1];
         default: bad = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= (state_ff == S_RUN && cdone) || state_ff == S_ERR;
      end
      if (start && state_ff == S_IDLE) begin
         op_ff  <= req_data.opcode;
         na_ff  <= a[Width-1];
         nb_ff  <= b[Width-1];
         err_ff <= err;
      end
      if (state_ff == S_ERR) begin
         rsp_ff <= '{result_high: '0, result_low: '0, status: err_ff};
      end else if (bad) begin
         rsp_ff <= '{result_high: '0, result_low: '0, status: ST_OVF};
      end else begin
         rsp_ff <= '{result_high: fixed[Width-1:Width/2],
                     result_low: fixed[Width/2-1:0], status: ST_OK};
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

FILE: hw/rtl/s128_checker.sv
// Port-level checker for the signed 128-bit ALU, bound to the top level.
module s128_checker import s128_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after transaction");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |->
      rsp_data.result_high == '0 && rsp_data.result_low == '0)
      else $error("error result not zero");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != 2'd3) else $error("bad status");
   a_valid_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result held two cycles");
endmodule

bind signed_int128_checked_alu s128_checker u_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);

FILE: test/alu128_checker.sv
// Checker: watches the command and result channels, predicts each result and compares.
module alu128_checker import s128_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);
   rsp_type expected_q[$];

   localparam logic [127:0] MinValue = {1'b1, 127'd0};

   function automatic logic [127:0] magnitude(logic [127:0] v);
      return v[127] ? -v : v;
   endfunction

   function automatic rsp_type alu_predict(req_type r);
      logic [127:0] a, b, sum, ma, mb, quo, rem_v;
      logic [255:0] prod;
      logic [1:0]   st;
      logic [127:0] val;
      a = {r.a_high, r.a_low};
      b = {r.b_high, r.b_low};
      st = ST_OK;
      val = '0;
      if (a == MinValue || b == MinValue || r.opcode > OP_REM) begin
         st = ST_OVF;
      end else if (r.opcode == OP_ADD || r.opcode == OP_SUB) begin
         sum = (r.opcode == OP_ADD) ? a + b : a - b;
         if (r.opcode == OP_ADD && a[127] == b[127] && sum[127] != a[127]) st = ST_OVF;
         if (r.opcode == OP_SUB && a[127] != b[127] && sum[127] != a[127]) st = ST_OVF;
         if (sum == MinValue) st = ST_OVF;
         val = sum;
      end else if (r.opcode == OP_MUL) begin
         ma = magnitude(a);
         mb = magnitude(b);
         prod = {128'd0, ma} * {128'd0, mb};
         if (prod[255:127] != '0) st = ST_OVF;
         else val = (a[127] != b[127]) ? -prod[127:0] : prod[127:0];
      end else if (b == '0) begin
         st = ST_DIV0;
      end else begin
         ma = magnitude(a);
         mb = magnitude(b);
         quo = ma / mb;
         rem_v = ma % mb;
         if (r.opcode == OP_DIV) val = (a[127] != b[127]) ? -quo : quo;
         else val = a[127] ? -rem_v : rem_v;
      end
      if (st != ST_OK) val = '0;
      alu_predict.result_high = val[127:64];
      alu_predict.result_low = val[63:0];
      alu_predict.status = st;
   endfunction

   task automatic report_mismatch(string what, logic [127:0] got, logic [127:0] want);
      $display("MISMATCH %s: got %h expected %h", what, got, want);
      fail_count++;
   endtask

   assign pending = expected_q.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected transaction", {rsp_data.result_high,
                  rsp_data.result_low}, '0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.result_high !== want.result_high)
                  report_mismatch("result_high", {64'd0, rsp_data.result_high},
                                  {64'd0, want.result_high});
               if (rsp_data.result_low !== want.result_low)
                  report_mismatch("result_low", {64'd0, rsp_data.result_low},
                                  {64'd0, want.result_low});
               if (rsp_data.status !== want.status)
                  report_mismatch("status", {126'd0, rsp_data.status},
                                  {126'd0, want.status});
            end
         end
         if (start && !busy) expected_q.push_back(alu_predict(req_data));
      end
   end
endmodule

FILE: test/tb_signed_int128_checked_alu.sv
// Testbench top: drives command transactions into the ALU and gives the verdict.
module tb_signed_int128_checked_alu import s128_pkg::*;;
   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   logic    rsp_valid;
   req_type req_data = '0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      idle_cycles = 0;

   localparam int IdleLimit = 3000;

   signed_int128_checked_alu u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   alu128_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .fail_count(fail_count),
      .pending(pending)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [127:0] rand128();
      logic [127:0] v;
      case ($urandom_range(0, 9))
         0: v = 128'd0;
         1: v = {1'b0, {127{1'b1}}};
         2: v = {1'b1, 126'd0, 1'b1};
         3: v = {1'b1, 127'd0};
         4: v = 128'($signed(32'($urandom)));
         5: v = 128'($signed({$urandom, $urandom}));
         6: v = {{64{1'b0}}, $urandom, $urandom} >> $urandom_range(0, 63);
         default: v = {$urandom, $urandom, $urandom, $urandom};
      endcase
      return v;
   endfunction

   // Issue one transaction; waits until the block takes it. start stays high
   // afterwards, the caller drops it after most bursts and at the end.
   task automatic send_op(logic [2:0] op, logic [127:0] a, logic [127:0] b);
      req_data <= '{opcode: op, a_high: a[127:64], a_low: a[63:0],
                    b_high: b[127:64], b_low: b[63:0]};
      start <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   initial begin
      logic [127:0] maxv, minv, one, neg1;
      logic [2:0]   op;
      int           burst;
      maxv = {1'b0, {127{1'b1}}};
      minv = {1'b1, 127'd0};
      one = 128'd1;
      neg1 = '1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_op(OP_ADD, maxv, one);
      send_op(OP_ADD, neg1, minv + 1);
      send_op(OP_SUB, minv + 1, one);
      send_op(OP_SUB, maxv, neg1);
      send_op(OP_ADD, maxv, neg1);
      send_op(OP_MUL, maxv, one);
      send_op(OP_MUL, maxv, neg1);
      send_op(OP_MUL, 128'd1 << 64, 128'd1 << 63);
      send_op(OP_MUL, 128'd1 << 63, 128'd1 << 63);
      send_op(OP_DIV, maxv, 128'd0);
      send_op(OP_REM, 128'd5, 128'd0);
      send_op(OP_DIV, minv, 128'd0);
      send_op(OP_DIV, -128'sd7, 128'd2);
      send_op(OP_REM, -128'sd7, 128'd2);
      send_op(OP_REM, 128'd7, -128'sd2);
      send_op(OP_DIV, maxv, neg1);
      send_op(OP_ADD, minv, 128'd0);
      send_op(OP_SUB, 128'd0, minv);
      send_op(3'd5, one, one);
      send_op(3'd6, one, one);
      send_op(3'd7, maxv, maxv);
      send_op(OP_REM, maxv, maxv);
      for (int n = 0; n < 1900; ) begin
         burst = $urandom_range(1, 8);
         for (int k = 0; k < burst; k++) begin
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            send_op(op, rand128(), rand128());
            n++;
         end
         if ($urandom_range(0, 2) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 200)) @(negedge clock);
         end
      end
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (140) @(posedge clock);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
